// ===== hdl/g4rle_pkg.sv =====
// Package for the 4-bit grey run-length encoder.
// Holds run limits, queue sizing, the code and queue-entry types, and the colour helper.
// No dependencies.
package g4rle_pkg;

  localparam int unsigned LONG_RUN_LIMIT  = 4095;
  localparam int unsigned SHORT_RUN_LIMIT = 15;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned COLOUR_W = 4;
  localparam int unsigned LEN_W    = 12;

  localparam logic [LEN_W-1:0] LONG_LIMIT  = LEN_W'(LONG_RUN_LIMIT & 'hFFF);
  localparam logic [LEN_W-1:0] SHORT_LIMIT = LEN_W'(SHORT_RUN_LIMIT);

  localparam logic [COLOUR_W-1:0] COLOUR_BLACK = 4'h0;
  localparam logic [COLOUR_W-1:0] COLOUR_WHITE = 4'hF;

  typedef struct packed {
    logic [COLOUR_W-1:0] colour;
    logic [LEN_W-1:0]    len;
  } code_t;

  // One accepted pixel's output: up to two run codes, in order a then b.
  typedef struct packed {
    logic  a_valid;
    code_t a;
    logic  b_valid;
    code_t b;
    logic  frame_last;
  } entry_t;

  function automatic logic is_long(input logic [COLOUR_W-1:0] colour);
    return (colour == COLOUR_BLACK) || (colour == COLOUR_WHITE);
  endfunction

endpackage

// ===== hdl/g4rle_front.sv =====
// Front end of the 4-bit grey run-length encoder: tracks the open run and
// classifies each pixel into zero, one or two run codes for the queue.
// Depends on g4rle_pkg.
module g4rle_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [7:0]        s_tdata_i,   // [7:0] pixel
  input  logic              s_tlast_i,   // last_pixel
  input  logic              q_full_i,
  output logic              q_push_o,
  output g4rle_pkg::entry_t q_entry_o
);

  logic [g4rle_pkg::COLOUR_W-1:0] colour_q, colour_d;
  logic                           open_q, open_d;
  logic [g4rle_pkg::LEN_W-1:0]    len_q, len_d;

  logic [g4rle_pkg::COLOUR_W-1:0] pix_colour;
  logic [g4rle_pkg::COLOUR_W-1:0] run_colour;
  logic [g4rle_pkg::LEN_W-1:0]    run_len;
  logic [g4rle_pkg::LEN_W-1:0]    limit;
  logic                           same;
  logic                           hit;
  logic                           accept;

  assign s_tready_o = !q_full_i;
  assign accept     = s_tvalid_i && s_tready_o;
  assign pix_colour = s_tdata_i[7:4];
  assign same       = open_q && (pix_colour == colour_q);

  always_comb begin
    run_colour = same ? colour_q : pix_colour;
    run_len    = same ? len_q + 1'b1 : {{(g4rle_pkg::LEN_W-1){1'b0}}, 1'b1};
    limit      = g4rle_pkg::is_long(run_colour) ? g4rle_pkg::LONG_LIMIT
                                                 : g4rle_pkg::SHORT_LIMIT;
    hit        = run_len >= limit;

    q_entry_o.a_valid    = open_q && !same;
    q_entry_o.a.colour   = colour_q;
    q_entry_o.a.len      = len_q;
    q_entry_o.b_valid    = hit || s_tlast_i;
    q_entry_o.b.colour   = run_colour;
    q_entry_o.b.len      = run_len;
    q_entry_o.frame_last = s_tlast_i;
    q_push_o = accept && (q_entry_o.a_valid || q_entry_o.b_valid);

    colour_d = colour_q;
    open_d   = open_q;
    len_d    = len_q;
    if (accept) begin
      colour_d = run_colour;
      open_d   = 1'b1;
      len_d    = run_len;
      if (hit || s_tlast_i) begin
        open_d = 1'b0;
        len_d  = '0;
      end
      if (s_tlast_i) begin
        colour_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_q <= '0;
      open_q   <= 1'b0;
      len_q    <= '0;
    end else begin
      colour_q <= colour_d;
      open_q   <= open_d;
      len_q    <= len_d;
    end
  end

endmodule

// ===== hdl/g4rle_queue.sv =====
// Short FIFO of run-code entries between the encoder front and back ends.
// Flip-flop storage, head entry read combinationally. Depends on g4rle_pkg.
module g4rle_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  g4rle_pkg::entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output g4rle_pkg::entry_t head_o
);

  g4rle_pkg::entry_t                mem_q [g4rle_pkg::QUEUE_DEPTH];
  logic [g4rle_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [g4rle_pkg::QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [g4rle_pkg::QUEUE_CNT_W-1:0] cnt_q, cnt_d;

  localparam logic [g4rle_pkg::QUEUE_PTR_W-1:0] LastPtr =
    g4rle_pkg::QUEUE_PTR_W'(g4rle_pkg::QUEUE_DEPTH - 1);
  localparam logic [g4rle_pkg::QUEUE_CNT_W-1:0] FullCnt =
    g4rle_pkg::QUEUE_CNT_W'(g4rle_pkg::QUEUE_DEPTH);

  assign full_o  = cnt_q == FullCnt;
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== hdl/g4rle_back.sv =====
// Back end of the 4-bit grey run-length encoder: serializes queued run codes
// into bytes through a registered output stage. Depends on g4rle_pkg.
module g4rle_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  g4rle_pkg::entry_t q_head_i,
  output logic              q_pop_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [7:0]        m_tdata_o,   // [7:0] out_byte
  output logic              m_tuser_o,   // run_last
  output logic              m_tlast_o    // frame_last
);

  g4rle_pkg::entry_t cur_q, cur_d;
  logic              cur_valid_q, cur_valid_d;
  logic              sel_b_q, sel_b_d;
  logic              lo_q, lo_d;
  logic              tvalid_q, tvalid_d;
  logic [7:0]        tdata_q, tdata_d;
  logic              tuser_q, tuser_d;
  logic              tlast_q, tlast_d;

  g4rle_pkg::code_t code;
  logic             long_code;
  logic [7:0]       byte_v;
  logic             code_end;
  logic             entry_end;
  logic             emit;

  assign m_tvalid_o = tvalid_q;
  assign m_tdata_o  = tdata_q;
  assign m_tuser_o  = tuser_q;
  assign m_tlast_o  = tlast_q;

  always_comb begin
    code      = sel_b_q ? cur_q.b : cur_q.a;
    long_code = g4rle_pkg::is_long(code.colour);
    if (!long_code) begin
      byte_v = {code.colour, code.len[3:0]};
    end else if (lo_q) begin
      byte_v = code.len[7:0];
    end else begin
      byte_v = {code.colour, code.len[11:8]};
    end
    code_end  = !long_code || lo_q;
    entry_end = code_end && (sel_b_q || !cur_q.b_valid);
    emit      = cur_valid_q && (!tvalid_q || m_tready_i);
    q_pop_o   = !q_empty_i && (!cur_valid_q || (emit && entry_end));

    tvalid_d = tvalid_q;
    tdata_d  = tdata_q;
    tuser_d  = tuser_q;
    tlast_d  = tlast_q;
    if (emit) begin
      tvalid_d = 1'b1;
      tdata_d  = byte_v;
      tuser_d  = entry_end;
      tlast_d  = entry_end && cur_q.frame_last;
    end else if (m_tready_i) begin
      tvalid_d = 1'b0;
    end

    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    sel_b_d     = sel_b_q;
    lo_d        = lo_q;
    if (emit) begin
      if (!code_end) begin
        lo_d = 1'b1;
      end else if (!entry_end) begin
        lo_d    = 1'b0;
        sel_b_d = 1'b1;
      end else begin
        lo_d        = 1'b0;
        cur_valid_d = 1'b0;
      end
    end
    if (q_pop_o) begin
      cur_d       = q_head_i;
      cur_valid_d = 1'b1;
      sel_b_d     = !q_head_i.a_valid;
      lo_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    tdata_q <= tdata_d;
    tuser_q <= tuser_d;
    tlast_q <= tlast_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      sel_b_q     <= 1'b0;
      lo_q        <= 1'b0;
      tvalid_q    <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      sel_b_q     <= sel_b_d;
      lo_q        <= lo_d;
      tvalid_q    <= tvalid_d;
    end
  end

  a_frame_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tlast_o |-> m_tuser_o)
    else $error("frame end without run end");

  a_lo_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q |-> cur_valid_q && long_code)
    else $error("low byte phase on a short code or no entry");

  a_code_a_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && !sel_b_q |-> cur_q.a_valid)
    else $error("serializing an absent first code");

  a_code_b_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && sel_b_q |-> cur_q.b_valid)
    else $error("serializing an absent second code");

endmodule

// ===== hdl/gray4_run_length_encoder.sv =====
// Run-length encoder for 4-bit grey images: pixel in, encoded bytes out.
// Throughput: one pixel per cycle into the front end while the queue has room;
// one byte per cycle out while m_tready_i is high; a pixel yields 0 to 4 bytes.
// A pixel's first byte passes the queue, the current-entry register and the output stage.
// Reset: asynchronous, active low; clears the open run, the queue and the output stage.
// Depends on g4rle_pkg, g4rle_front, g4rle_queue, g4rle_back.
module gray4_run_length_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,   // [7:0] pixel
  input  logic       s_tlast_i,   // last_pixel
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,   // [7:0] out_byte
  output logic       m_tuser_o,   // run_last
  output logic       m_tlast_o    // frame_last
);

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  g4rle_pkg::entry_t q_entry;
  g4rle_pkg::entry_t q_head;

  g4rle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry)
  );

  g4rle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  g4rle_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for gray4_run_length_encoder: pixel stream in, encoded bytes out.
// Directed table, then random frames; bytes checked against typed bytes or a run predictor.
// Depends on g4rle_pkg and the encoder RTL.
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       frame_last;
  } enc_byte_t;

  typedef struct packed {
    logic [7:0]          pixel;
    logic                last;
    int unsigned         reps;
    int                  n;       // typed byte count, -1 = use predictor
    enc_byte_t [0:3]     typed;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid_i = 1'b0;
  logic       s_tready_o;
  logic [7:0] s_tdata_i = 8'h00;   // [7:0] pixel
  logic       s_tlast_i = 1'b0;    // last_pixel
  logic       m_tvalid_o;
  logic       m_tready_i = 1'b0;
  logic [7:0] m_tdata_o;           // [7:0] out_byte
  logic       m_tuser_o;           // run_last
  logic       m_tlast_o;           // frame_last

  enc_byte_t   expected_bytes[$];
  enc_byte_t   staged[$];
  stim_row_t   dir_rows[$];
  int unsigned n_errors = 0;
  int unsigned pixels_sent = 0;
  int unsigned calm_start = 32'hFFFF_FFFF;
  logic        calm = 1'b0;

  logic [g4rle_pkg::COLOUR_W-1:0] run_colour_q = '0;
  logic                           run_open_q = 1'b0;
  logic [g4rle_pkg::LEN_W-1:0]    run_len_q = '0;

  gray4_run_length_encoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("gray4_run_length_encoder regression: fail");
    $finish;
  end

  // emit the open run's code into staged and close it
  function automatic void flush_run();
    logic [15:0] word;
    word = {run_colour_q, run_len_q};
    if (run_colour_q == g4rle_pkg::COLOUR_BLACK || run_colour_q == g4rle_pkg::COLOUR_WHITE) begin
      staged.insert(staged.size(),
                    enc_byte_t'{data: word[15:8], run_last: 1'b0, frame_last: 1'b0});
      staged.insert(staged.size(),
                    enc_byte_t'{data: word[7:0], run_last: 1'b0, frame_last: 1'b0});
    end else begin
      staged.insert(staged.size(),
                    enc_byte_t'{data: {run_colour_q, run_len_q[3:0]}, run_last: 1'b0,
                                frame_last: 1'b0});
    end
    run_open_q = 1'b0;
    run_len_q  = '0;
  endfunction

  function automatic void encode_pixel(input logic [7:0] pix, input logic lst);
    logic [g4rle_pkg::COLOUR_W-1:0] colour;
    logic [g4rle_pkg::LEN_W-1:0]    limit;
    colour = pix[7:4];
    staged.delete();
    if (run_open_q && colour == run_colour_q) begin
      run_len_q = run_len_q + 1'b1;
    end else begin
      if (run_open_q) flush_run();
      run_colour_q = colour;
      run_open_q   = 1'b1;
      run_len_q    = g4rle_pkg::LEN_W'(1);
    end
    limit = (run_colour_q == g4rle_pkg::COLOUR_BLACK ||
             run_colour_q == g4rle_pkg::COLOUR_WHITE) ?
            g4rle_pkg::LONG_LIMIT : g4rle_pkg::SHORT_LIMIT;
    if (run_open_q && run_len_q >= limit) flush_run();
    if (lst) begin
      if (run_open_q) flush_run();
      run_colour_q = '0;
      run_open_q   = 1'b0;
      run_len_q    = '0;
    end
    if (staged.size() > 0) begin
      staged[staged.size()-1].run_last   = 1'b1;
      staged[staged.size()-1].frame_last = lst;
    end
  endfunction

  task automatic send_pixel(input logic [7:0] pix, input logic lst, input logic predicted);
    calm = (pixels_sent >= calm_start) && (pixels_sent < calm_start + 100);
    while (!calm && $urandom_range(0, 99) < 37) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= pix;
    s_tlast_i  <= lst;
    do @(posedge clk_i); while (!s_tready_o);
    pixels_sent++;
    encode_pixel(pix, lst);
    if (predicted) foreach (staged[k]) expected_bytes.insert(expected_bytes.size(), staged[k]);
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  // output side: random backpressure and byte check
  always @(posedge clk_i) begin
    enc_byte_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected transfer: out_byte %h", m_tdata_o);
        n_errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata_o !== want.data) begin
          $error("out_byte: expected %h, actual %h", want.data, m_tdata_o);
          n_errors++;
        end
        if (m_tuser_o !== want.run_last) begin
          $error("run_last: expected %b, actual %b", want.run_last, m_tuser_o);
          n_errors++;
        end
        if (m_tlast_o !== want.frame_last) begin
          $error("frame_last: expected %b, actual %b", want.frame_last, m_tlast_o);
          n_errors++;
        end
      end
    end
    m_tready_i <= calm || ($urandom_range(0, 99) >= 37);
  end

  initial begin
    int unsigned first_rand;
    int unsigned nruns;
    int unsigned run_len;
    int unsigned pick;
    logic [3:0]  colour;
    bit          drained_mid;

    drained_mid = 1'b0;
    // pixel, last, reps, n, typed bytes {data, run_last, frame_last} first byte on top
    dir_rows = '{
      '{8'h00, 1'b1, 1,    2,  {8'h00, 2'b00, 8'h01, 2'b11, 20'd0}},
      '{8'hFF, 1'b1, 1,    2,  {8'hF0, 2'b00, 8'h01, 2'b11, 20'd0}},
      '{8'h7A, 1'b1, 1,    1,  {8'h71, 2'b11, 30'd0}},
      '{8'h35, 1'b0, 15,   1,  {8'h3F, 2'b10, 30'd0}},
      '{8'h35, 1'b1, 1,    1,  {8'h31, 2'b11, 30'd0}},
      '{8'h00, 1'b0, 1,    0,  40'd0},
      '{8'hF3, 1'b1, 1,    4,  {8'h00, 2'b00, 8'h01, 2'b00, 8'hF0, 2'b00, 8'h01, 2'b11}},
      '{8'h10, 1'b0, 3,    0,  40'd0},
      '{8'h20, 1'b1, 1,    2,  {8'h13, 2'b00, 8'h21, 2'b11, 20'd0}},
      '{8'hE5, 1'b0, 1,    0,  40'd0},
      '{8'hD5, 1'b0, 1,    1,  {8'hE1, 2'b10, 30'd0}},
      '{8'hD5, 1'b1, 1,    1,  {8'hD2, 2'b11, 30'd0}},
      '{8'h80, 1'b0, 14,   0,  40'd0},
      '{8'h8F, 1'b1, 1,    1,  {8'h8F, 2'b11, 30'd0}},
      '{8'hA0, 1'b0, 1,    -1, 40'd0},
      '{8'h0C, 1'b0, 2,    -1, 40'd0},
      '{8'hC4, 1'b0, 1,    -1, 40'd0},
      '{8'hFF, 1'b0, 1,    -1, 40'd0},
      '{8'h00, 1'b1, 1,    -1, 40'd0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      for (int r = 0; r < dir_rows[i].reps; r++)
        send_pixel(dir_rows[i].pixel, dir_rows[i].last, dir_rows[i].n < 0);
      for (int k = 0; k < dir_rows[i].n; k++)
        expected_bytes.insert(expected_bytes.size(), dir_rows[i].typed[k]);
    end
    drain();

    first_rand = pixels_sent;
    calm_start = first_rand + 150;
    while (pixels_sent - first_rand < 480) begin
      if (!drained_mid && pixels_sent - first_rand >= 300) begin
        drain();
        drained_mid = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // noise: unrelated pixels, stray frame ends
        repeat ($urandom_range(1, 6))
          send_pixel(8'($urandom), $urandom_range(0, 7) == 0, 1'b1);
      end else begin
        nruns = $urandom_range(1, 6);
        for (int j = 0; j < nruns; j++) begin
          pick = $urandom_range(0, 9);
          if (pick < 3) colour = g4rle_pkg::COLOUR_BLACK;
          else if (pick < 6) colour = g4rle_pkg::COLOUR_WHITE;
          else colour = 4'($urandom_range(1, 14));
          pick = $urandom_range(0, 9);
          if (pick < 6) run_len = $urandom_range(1, 3);
          else if (pick < 8) run_len = $urandom_range(13, 17);
          else if (pick == 8) run_len = $urandom_range(28, 32);
          else run_len = $urandom_range(1, 60);
          for (int p = 0; p < run_len; p++)
            send_pixel({colour, 4'($urandom)}, (j == nruns - 1) && (p == run_len - 1), 1'b1);
        end
      end
    end
    send_pixel(8'($urandom), 1'b1, 1'b1);
    s_tvalid_i <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("gray4_run_length_encoder regression: pass");
    end else begin
      $display("gray4_run_length_encoder regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/g4rle_pkg.sv
hdl/g4rle_front.sv
hdl/g4rle_queue.sv
hdl/g4rle_back.sv
hdl/gray4_run_length_encoder.sv
verif/testbench.sv
